### rtl/core/checked_int64_alu_top_defines.svh
// assertion macros for the checked int64 alu
// used by checked_int64_alu_top; expects clk and arst_n in scope
`ifndef CHECKED_INT64_ALU_TOP_DEFINES_SVH
`define CHECKED_INT64_ALU_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, off while reset is asserted
`define CIA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked property, also during reset
`define CIA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CIA_ASSERT(lbl, prop, msg)
`define CIA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### rtl/core/cia_pkg.sv
// shared types and constants for the checked int64 alu
// no dependencies
package cia_pkg;

	localparam int DIV_STEPS = 64;
	localparam logic [63:0] INT_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_MOD = 4'd4,
		OP_NEG = 4'd5,
		OP_ABS = 4'd6,
		OP_INC = 4'd7,
		OP_DEC = 4'd8,
		OP_CMP = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVF   = 2'd1,
		ST_DIV0  = 2'd2,
		ST_BADOP = 2'd3
	} status_t;

	// per-beat control that travels down the pipeline
	typedef struct packed {
		op_t         op;
		logic        neg_q;
		logic        neg_r;
		status_t     status;
		logic [63:0] result;
	} ctl_t;

endpackage

### rtl/core/cia_prep.sv
// first stage: decode, operand magnitudes, short operations and error checks
// depends on cia_pkg
module cia_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [3:0]         op,
	input  logic signed [63:0] lhs_value,
	input  logic signed [63:0] rhs_value,
	output logic               valid_s1,
	output cia_pkg::ctl_t      ctl_s1,
	output logic [63:0]        ma_s1,
	output logic [63:0]        mb_s1
);
	import cia_pkg::*;

	logic        an;
	logic        bn;
	logic [63:0] ma;
	logic [63:0] mb;
	logic [63:0] sum;
	logic [63:0] diff;
	logic [63:0] res;
	status_t     st;
	op_t         opc;
	ctl_t        ctl;

	// magnitudes and simple results
	always_comb begin
		opc  = op_t'(op);
		an   = lhs_value[63];
		bn   = rhs_value[63];
		ma   = an ? (~lhs_value + 64'd1) : lhs_value;
		mb   = bn ? (~rhs_value + 64'd1) : rhs_value;
		sum  = lhs_value + rhs_value;
		diff = lhs_value - rhs_value;
		res  = '0;
		st   = ST_OK;
		case (opc)
			OP_ADD: begin
				res = sum;
				if ((an == bn) && (sum[63] != an)) st = ST_OVF;
			end
			OP_SUB: begin
				res = diff;
				if ((an != bn) && (diff[63] != an)) st = ST_OVF;
			end
			OP_MUL: begin
				res = '0;
			end
			OP_DIV: begin
				if (rhs_value == '0) st = ST_DIV0;
				else if ((lhs_value == INT_MIN) && (&rhs_value)) st = ST_OVF;
			end
			OP_MOD: begin
				if (rhs_value == '0) st = ST_DIV0;
			end
			OP_NEG: begin
				res = ~lhs_value + 64'd1;
				if (lhs_value == INT_MIN) st = ST_OVF;
			end
			OP_ABS: begin
				res = ma;
				if (lhs_value == INT_MIN) st = ST_OVF;
			end
			OP_INC: begin
				res = lhs_value + 64'd1;
				if (lhs_value == INT_MAX) st = ST_OVF;
			end
			OP_DEC: begin
				res = lhs_value - 64'd1;
				if (lhs_value == INT_MIN) st = ST_OVF;
			end
			OP_CMP: begin
				if (lhs_value == rhs_value) res = '0;
				else if (lhs_value < rhs_value) res = '1;
				else res = 64'd1;
			end
			default: begin
				st = ST_BADOP;
			end
		endcase
		if (st != ST_OK) res = '0;
		ctl.op     = opc;
		ctl.neg_q  = an ^ bn;
		ctl.neg_r  = an;
		ctl.status = st;
		ctl.result = res;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			ma_s1  <= ma;
			mb_s1  <= mb;
		end
	end

endmodule

### rtl/core/cia_mul.sv
// four-stage 64x64 magnitude multiplier built from 32x32 partial products
// depends on cia_pkg; merges the product and its overflow into the control
module cia_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_s1,
	input  cia_pkg::ctl_t ctl_s1,
	input  logic [63:0]   ma_s1,
	input  logic [63:0]   mb_s1,
	output logic          valid_s5,
	output cia_pkg::ctl_t ctl_s5,
	output logic [63:0]   ma_s5,
	output logic [63:0]   mb_s5
);
	import cia_pkg::*;

	logic          valid_s2, valid_s3, valid_s4;
	ctl_t          ctl_s2, ctl_s3, ctl_s4;
	logic [63:0]   ma_s2, ma_s3, ma_s4;
	logic [63:0]   mb_s2, mb_s3, mb_s4;
	logic [63:0]   p00_s2, p01_s2, p10_s2, p11_s2;
	logic [63:0]   p00_s3, p11_s3;
	logic [64:0]   mid_s3;
	logic [127:0]  prod_s4;
	logic          ovf;
	logic [63:0]   mres;
	ctl_t          ctl_m;

	// overflow against the signed limit, then sign the low word
	always_comb begin
		ovf = (|prod_s4[127:64]) |
			(prod_s4[63] & (~ctl_s4.neg_q | (|prod_s4[62:0])));
		mres = ctl_s4.neg_q ? (~prod_s4[63:0] + 64'd1) : prod_s4[63:0];
		ctl_m = ctl_s4;
		if (ctl_s4.op == OP_MUL) begin
			ctl_m.status = ovf ? ST_OVF : ST_OK;
			ctl_m.result = ovf ? '0 : mres;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// partial products, middle sum, full product, merge
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2  <= ma_s1[31:0] * mb_s1[31:0];
			p01_s2  <= ma_s1[31:0] * mb_s1[63:32];
			p10_s2  <= ma_s1[63:32] * mb_s1[31:0];
			p11_s2  <= ma_s1[63:32] * mb_s1[63:32];
			p00_s3  <= p00_s2;
			p11_s3  <= p11_s2;
			mid_s3  <= {1'b0, p01_s2} + {1'b0, p10_s2};
			prod_s4 <= {p11_s3, p00_s3} + {31'd0, mid_s3, 32'd0};
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_m;
			ma_s2   <= ma_s1;
			ma_s3   <= ma_s2;
			ma_s4   <= ma_s3;
			ma_s5   <= ma_s4;
			mb_s2   <= mb_s1;
			mb_s3   <= mb_s2;
			mb_s4   <= mb_s3;
			mb_s5   <= mb_s4;
		end
	end

endmodule

### rtl/core/cia_div.sv
// restoring divider, one quotient bit per pipeline stage
// depends on cia_pkg; carries the control alongside
module cia_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          valid_in,
	input  cia_pkg::ctl_t ctl_in,
	input  logic [63:0]   dividend,
	input  logic [63:0]   divisor,
	output logic          valid_out,
	output cia_pkg::ctl_t ctl_out,
	output logic [63:0]   quo_out,
	output logic [63:0]   rem_out
);
	import cia_pkg::*;

	// index 0 is the stage input, index k the register after step k
	logic        valid_s [0:DIV_STEPS];
	ctl_t        ctl_s   [0:DIV_STEPS];
	logic [63:0] rem_s   [0:DIV_STEPS];
	logic [63:0] quo_s   [0:DIV_STEPS];
	logic [63:0] dsr_s   [0:DIV_STEPS];

	assign valid_s[0] = valid_in;
	assign ctl_s[0]   = ctl_in;
	assign rem_s[0]   = '0;
	assign quo_s[0]   = dividend;
	assign dsr_s[0]   = divisor;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [64:0] trial;
		logic [65:0] sub;
		logic        ge;

		// shift in the next dividend bit and try the subtract
		always_comb begin
			trial = {rem_s[k], quo_s[k][63]};
			sub   = {1'b0, trial} - {2'b00, dsr_s[k]};
			ge    = ~sub[65];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k+1] <= ctl_s[k];
				dsr_s[k+1] <= dsr_s[k];
				rem_s[k+1] <= ge ? sub[63:0] : trial[63:0];
				quo_s[k+1] <= {quo_s[k][62:0], ge};
			end
		end
	end

	assign valid_out = valid_s[DIV_STEPS];
	assign ctl_out   = ctl_s[DIV_STEPS];
	assign quo_out   = quo_s[DIV_STEPS];
	assign rem_out   = rem_s[DIV_STEPS];

endmodule

### rtl/core/checked_int64_alu_top.sv
// Overflow-checked signed 64-bit alu. One beat is accepted per cycle while
// req_stall is low, and each beat yields exactly one result beat, in order.
// The divider produces one quotient bit per pipeline stage over 64 stages;
// every operation goes through the same stages so results keep their order. A
// two-entry output buffer decouples the pipeline from the result side;
// req_stall rises only when that buffer is full. Nonzero status always comes
// with a zero value.
// depends on cia_pkg, cia_prep, cia_mul, cia_div and the defines header
`include "checked_int64_alu_top_defines.svh"

module checked_int64_alu_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [3:0]           op,
	input  logic signed [63:0]   lhs_value,
	input  logic signed [63:0]   rhs_value,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic signed [63:0]   result_value,
	output cia_pkg::status_t     status
);
	import cia_pkg::*;

	logic        en;
	logic        valid_s1, valid_s5, valid_d;
	ctl_t        ctl_s1, ctl_s5, ctl_d;
	logic [63:0] ma_s1, mb_s1, ma_s5, mb_s5;
	logic [63:0] quo_d, rem_d;
	logic [63:0] fin_res;
	logic        push, pop;
	logic [1:0]  cnt_q;
	logic        wr_ptr_q, rd_ptr_q;
	logic [63:0] buf_res_q [0:1];
	status_t     buf_st_q  [0:1];

	// whole pipeline moves unless the output buffer is full
	assign en        = (cnt_q != 2'd2);
	assign req_stall = ~en;

	cia_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (req_valid),
		.op        (op),
		.lhs_value (lhs_value),
		.rhs_value (rhs_value),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.ma_s1     (ma_s1),
		.mb_s1     (mb_s1)
	);

	cia_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.ctl_s1   (ctl_s1),
		.ma_s1    (ma_s1),
		.mb_s1    (mb_s1),
		.valid_s5 (valid_s5),
		.ctl_s5   (ctl_s5),
		.ma_s5    (ma_s5),
		.mb_s5    (mb_s5)
	);

	cia_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s5),
		.ctl_in    (ctl_s5),
		.dividend  (ma_s5),
		.divisor   (mb_s5),
		.valid_out (valid_d),
		.ctl_out   (ctl_d),
		.quo_out   (quo_d),
		.rem_out   (rem_d)
	);

	// sign fix for divide and remainder, everything else already final
	always_comb begin
		case (ctl_d.op)
			OP_DIV:  fin_res = ctl_d.neg_q ? (~quo_d + 64'd1) : quo_d;
			OP_MOD:  fin_res = ctl_d.neg_r ? (~rem_d + 64'd1) : rem_d;
			default: fin_res = ctl_d.result;
		endcase
		if (ctl_d.status != ST_OK) fin_res = '0;
	end

	assign push = en & valid_d;
	assign pop  = rsp_valid & ~rsp_stall;

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// output buffer entries
	always_ff @(posedge clk) begin
		if (push) begin
			buf_res_q[wr_ptr_q] <= fin_res;
			buf_st_q[wr_ptr_q]  <= ctl_d.status;
		end
	end

	assign rsp_valid    = (cnt_q != 2'd0);
	assign result_value = buf_res_q[rd_ptr_q];
	assign status       = buf_st_q[rd_ptr_q];

	// buffer never holds more than two beats
	`CIA_ASSERT(a_cnt_range, (cnt_q != 2'd3), "output buffer count out of range")
	// a full buffer accepts nothing until a beat leaves
	`CIA_ASSERT(a_full_hold, ((cnt_q == 2'd2) && !pop |=> (cnt_q == 2'd2)), "full buffer changed without pop")
	// an error beat carries a zero value
	`CIA_ASSERT(a_err_zero, (rsp_valid && (status != ST_OK) |-> (result_value == '0)), "error beat with nonzero value")
	// only a pipeline exit can raise the count
	`CIA_ASSERT(a_cnt_push, ((cnt_q > $past(cnt_q)) |-> $past(valid_d && en)), "count rose without a push")

endmodule

### sim/checked_int64_alu_top_test.sv
// testbench for checked_int64_alu_top: directed table plus random beats,
// each result checked in order against an inline predictor
// depends on cia_pkg and the checked_int64_alu_top rtl
`timescale 1ns / 100ps

module checked_int64_alu_top_test;
	import cia_pkg::*;

	localparam int LATENCY = 69;
	localparam int N_RANDOM = 1800;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic [3:0]  op;
		logic [63:0] a;
		logic [63:0] b;
		logic        known;
		logic [63:0] r;
		status_t     st;
	} row_t;

	typedef struct {
		logic [63:0] r;
		status_t     st;
	} alu_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [3:0] op = '0;
	logic signed [63:0] lhs_value = '0;
	logic signed [63:0] rhs_value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [63:0] result_value;
	status_t status;

	alu_out_t pending_results[$];
	int errors = 0;
	longint cycles = 0;
	int send_idle_pct = 32;
	int recv_idle_pct = 64;
	int hold_cycles = 0;

	checked_int64_alu_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .lhs_value(lhs_value), .rhs_value(rhs_value),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.result_value(result_value), .status(status)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] magnitude(logic [63:0] v);
		return v[63] ? -v : v;
	endfunction

	// checked arithmetic on one beat
	function automatic alu_out_t checked_alu(logic [3:0] code, logic [63:0] a, logic [63:0] b);
		alu_out_t o;
		logic [63:0] ma, mb, q, lim;
		logic [127:0] prod;
		o.r = '0;
		o.st = ST_OK;
		ma = magnitude(a);
		mb = magnitude(b);
		case (code)
			OP_ADD: begin
				o.r = a + b;
				if (a[63] == b[63] && o.r[63] != a[63]) o.st = ST_OVF;
			end
			OP_SUB: begin
				o.r = a - b;
				if (a[63] != b[63] && o.r[63] != a[63]) o.st = ST_OVF;
			end
			OP_MUL: begin
				prod = {64'd0, ma} * {64'd0, mb};
				lim = (a[63] != b[63]) ? INT_MIN : INT_MAX;
				if (prod > {64'd0, lim}) o.st = ST_OVF;
				else o.r = a * b;
			end
			OP_DIV: begin
				if (b == 64'd0) o.st = ST_DIV0;
				else if (a == INT_MIN && b == ONES) o.st = ST_OVF;
				else begin
					q = ma / mb;
					o.r = (a[63] != b[63]) ? -q : q;
				end
			end
			OP_MOD: begin
				if (b == 64'd0) o.st = ST_DIV0;
				else begin
					q = ma % mb;
					o.r = a[63] ? -q : q;
				end
			end
			OP_NEG: if (a == INT_MIN) o.st = ST_OVF; else o.r = -a;
			OP_ABS: if (a == INT_MIN) o.st = ST_OVF; else o.r = ma;
			OP_INC: if (a == INT_MAX) o.st = ST_OVF; else o.r = a + 64'd1;
			OP_DEC: if (a == INT_MIN) o.st = ST_OVF; else o.r = a - 64'd1;
			OP_CMP: o.r = ($signed(a) == $signed(b)) ? 64'd0 :
				($signed(a) < $signed(b)) ? ONES : 64'd1;
			default: o.st = ST_BADOP;
		endcase
		if (o.st != ST_OK) o.r = '0;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp_v, cycles);
		errors++;
	endtask

	// random operand biased toward edges
	function automatic logic [63:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return INT_MIN;
			1: return INT_MAX;
			2: return 64'(signed'($urandom_range(0, 6)) - 3);
			3: return {32'd0, $urandom};
			4: return {{32{1'b1}}, $urandom};
			5: return 64'(signed'($urandom_range(0, 32'h7FFF_FFFF)) - 32'sd1073741824);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// send one beat, holding it until accepted
	task automatic send_beat(logic [3:0] code, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		op <= code;
		lhs_value <= a;
		rhs_value <= b;
		pending_results.push_back(checked_alu(code, a, b));
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// receiver stall, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// result checking
	always @(posedge clk) begin
		alu_out_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", result_value, 64'd0);
			end else begin
				e = pending_results.pop_front();
				if (result_value !== e.r) report_mismatch("result_value", result_value, e.r);
				if (status !== e.st) report_mismatch("status", 64'(status), 64'(e.st));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("checked_int64_alu_top test failed");
			$finish;
		end
	end

	row_t directed[$];

	task automatic add_row(logic [3:0] c, logic [63:0] a, logic [63:0] b, logic k,
			logic [63:0] r, status_t st);
		row_t t;
		t.op = c; t.a = a; t.b = b; t.known = k; t.r = r; t.st = st;
		directed.push_back(t);
	endtask

	initial begin
		alu_out_t p;
		logic [3:0] c;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed expectations where obvious
		add_row(OP_ADD, INT_MAX, 64'd1, 1'b1, 64'd0, ST_OVF);
		add_row(OP_ADD, INT_MIN, ONES, 1'b1, 64'd0, ST_OVF);
		add_row(OP_SUB, INT_MIN, 64'd1, 1'b1, 64'd0, ST_OVF);
		add_row(OP_SUB, 64'd5, 64'd7, 1'b1, ONES - 64'd1, ST_OK);
		add_row(OP_MUL, INT_MAX, 64'd2, 1'b1, 64'd0, ST_OVF);
		add_row(OP_MUL, INT_MIN, 64'd1, 1'b1, INT_MIN, ST_OK);
		add_row(OP_MUL, INT_MIN, ONES, 1'b1, 64'd0, ST_OVF);
		add_row(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000, 1'b0, 64'd0, ST_OK);
		add_row(OP_DIV, 64'd7, 64'd0, 1'b1, 64'd0, ST_DIV0);
		add_row(OP_DIV, INT_MIN, ONES, 1'b1, 64'd0, ST_OVF);
		add_row(OP_DIV, -64'd7, 64'd2, 1'b1, -64'd3, ST_OK);
		add_row(OP_MOD, 64'd7, 64'd0, 1'b1, 64'd0, ST_DIV0);
		add_row(OP_MOD, INT_MIN, ONES, 1'b1, 64'd0, ST_OK);
		add_row(OP_MOD, -64'd7, 64'd2, 1'b1, ONES, ST_OK);
		add_row(OP_MOD, INT_MAX, 64'd1, 1'b1, 64'd0, ST_OK);
		add_row(OP_NEG, INT_MIN, 64'd0, 1'b1, 64'd0, ST_OVF);
		add_row(OP_NEG, INT_MAX, ONES, 1'b1, INT_MIN + 64'd1, ST_OK);
		add_row(OP_ABS, INT_MIN, 64'd0, 1'b1, 64'd0, ST_OVF);
		add_row(OP_ABS, ONES, 64'd0, 1'b1, 64'd1, ST_OK);
		add_row(OP_INC, INT_MAX, 64'd0, 1'b1, 64'd0, ST_OVF);
		add_row(OP_DEC, INT_MIN, 64'd0, 1'b1, 64'd0, ST_OVF);
		add_row(OP_CMP, INT_MIN, INT_MAX, 1'b1, ONES, ST_OK);
		add_row(OP_CMP, INT_MAX, INT_MIN, 1'b1, 64'd1, ST_OK);
		add_row(OP_CMP, ONES, ONES, 1'b1, 64'd0, ST_OK);
		add_row(4'd15, ONES, ONES, 1'b1, 64'd0, ST_BADOP);

		foreach (directed[i]) begin
			p = checked_alu(directed[i].op, directed[i].a, directed[i].b);
			if (directed[i].known && (p.r !== directed[i].r || p.st !== directed[i].st))
				report_mismatch("directed row", p.r, directed[i].r);
			send_beat(directed[i].op, directed[i].a, directed[i].b);
		end

		// random beats over three idling phases
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 32;
			end
			if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// long receiver hold-off so the block fills and stalls its input
			if (n == N_RANDOM / 2) hold_cycles <= 1000;
			// sender pauses until everything has drained
			if (n == N_RANDOM / 4) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) @(posedge clk);
			end
			c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			send_beat(c, rand_operand(), rand_operand());
		end
		req_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0) begin
			$display("checked_int64_alu_top test passed");
		end else begin
			$display("checked_int64_alu_top test failed");
		end
		$finish;
	end
endmodule

### checked_int64_alu_top.f
+incdir+rtl/core
rtl/core/cia_pkg.sv
rtl/core/cia_prep.sv
rtl/core/cia_mul.sv
rtl/core/cia_div.sv
rtl/core/checked_int64_alu_top.sv
sim/checked_int64_alu_top_test.sv
